// ===== src/gww_pkg.sv =====
// ----------------------------------------------------------------------------
// gww_pkg: shared types and constants of the greedy word wrap stream
// Character codes, register reset values, the emission phase type and the
// plan of pending emission jobs.
// ----------------------------------------------------------------------------
`default_nettype none

package gww_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned LW_W         = 10;
   localparam int unsigned COL_W        = 11;
   localparam int unsigned RESULT_CAP   = 50;
   localparam int unsigned RC_W         = $clog2(RESULT_CAP + 1);

   localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

   localparam logic [LW_W-1:0]  DEFAULT_WIDTH = 10'd75;
   localparam logic [COL_W-1:0] COL_MAX       = 11'd2047;

   // Source of one output byte.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_NL_A,
      PH_NL_B,
      PH_BRK,
      PH_IND,
      PH_SPC,
      PH_WRD,
      PH_EOF_NL
   } phase_type;

   // Jobs still to be emitted for the current item, in emission order.
   typedef struct packed {
      logic nl_a;
      logic nl_b;
      logic brk;
      logic ind;
      logic spc;
      logic wrd;
      logic eof_nl;
   } plan_type;

   function automatic logic is_white(input logic [BYTE_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

`default_nettype wire

// ===== src/gww_if.sv =====
// ----------------------------------------------------------------------------
// gww_if: stream channels of the greedy word wrap block
// Valid/ready channels for input text bytes and formatted output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gww_req_if;
   import gww_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_file;

   modport source (output valid, output in_byte, output end_of_file, input ready);
   modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface gww_rsp_if;
   import gww_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;
   logic              truncated;

   modport source (output valid, output out_byte, output last_of_run, output truncated,
                   input ready);
   modport sink   (input valid, input out_byte, input last_of_run, input truncated,
                   output ready);
endinterface

`default_nettype wire

// ===== src/greedy_word_wrap_stream.sv =====
// ----------------------------------------------------------------------------
// greedy_word_wrap_stream: greedy paragraph refill of a UTF-8 byte stream
// Buffers words and the paragraph indent in small memories and replays them
// as formatted output bytes.
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer on req_if and produces the
// refilled text on rsp_if, one byte per transfer, with last_of_run marking
// the final byte caused by an input byte. An input byte that produces no
// output leaves req_if ready. One that produces output holds req_if through
// its decode and the issue of each output byte, as the word and indent
// buffers each have one read port that yields one byte per cycle while the
// output path has room. A two-entry output path (memory read stage and
// output register) lets the sequencer run on while the consumer stalls,
// until both entries are full, and the next input byte is taken as soon as
// the last output byte of the previous one is issued. There is no clearing
// pass after reset; zero line_width means 75. The user must write line_width
// through csr_we/csr_wdata only while the block is idle; it is not enforced.
`default_nettype none

module greedy_word_wrap_stream #(
   parameter int unsigned WORD_BYTES   = 32,
   parameter int unsigned INDENT_BYTES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   gww_req_if.sink                     req_if,
   gww_rsp_if.source                   rsp_if,
   input  wire logic                   csr_we,
   input  wire logic [gww_pkg::LW_W-1:0] csr_wdata
);
   import gww_pkg::*;

   localparam int unsigned WL_W  = $clog2(WORD_BYTES + 1);
   localparam int unsigned IL_W  = $clog2(INDENT_BYTES + 1);
   localparam int unsigned WA_W  = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
   localparam int unsigned IA_W  = (INDENT_BYTES > 1) ? $clog2(INDENT_BYTES) : 1;
   localparam int unsigned CNT_W = (WL_W > IL_W) ? WL_W : IL_W;

   // ------------------------------------------------------------------------
   // Architectural state.
   // ------------------------------------------------------------------------
   logic [LW_W-1:0]  lw_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic             ps_ff, ps_in;          // paragraph start
   logic             ils_ff, ils_in;        // still in leading whitespace of a line
   logic [IL_W-1:0]  ilen_ff, ilen_in;
   logic             icut_ff, icut_in;
   logic [WL_W-1:0]  wlen_ff, wlen_in;
   logic [WL_W-1:0]  wchars_ff, wchars_in;
   logic             wovf_ff, wovf_in;

   // The two buffers. Their contents are only read below the stored lengths.
   logic [BYTE_W-1:0] ind_mem [INDENT_BYTES];
   logic [BYTE_W-1:0] wrd_mem [WORD_BYTES];

   // ------------------------------------------------------------------------
   // Emission sequencer: pending jobs, byte index, result count and the
   // lengths and cut flags frozen at decode time.
   // ------------------------------------------------------------------------
   plan_type         rem_ff, rem_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [RC_W-1:0]  cnt_ff, cnt_in;
   logic [IL_W-1:0]  p_ilen_ff;
   logic             p_icut_ff;
   logic [WL_W-1:0]  p_wlen_ff;
   logic             p_wovf_ff;

   // Read stage and output register.
   logic              s1_vld_ff;
   phase_type         s1_kind_ff;
   logic              s1_last_ff;
   logic              s1_trunc_ff;
   logic [BYTE_W-1:0] ind_rd_ff;
   logic [BYTE_W-1:0] wrd_rd_ff;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic              rsp_trunc_ff;

   logic              accept;
   logic              s1_move;
   logic              issue;

   // Decode results.
   logic              ind_we;
   logic              wrd_we;
   plan_type          plan;

   // Sequencer step results.
   phase_type         phase;
   logic              step_last;
   logic              step_trunc;

   // ------------------------------------------------------------------------
   // Handshakes. A new byte is taken only when no job of the previous byte
   // remains to be issued; the read stage and output register drain on their
   // own.
   // ------------------------------------------------------------------------
   assign req_if.ready = (rem_ff == '0);
   assign accept       = req_if.valid && req_if.ready;
   assign s1_move      = s1_vld_ff && (!rsp_valid_ff || rsp_if.ready);
   assign issue        = (rem_ff != '0) && (!s1_vld_ff || s1_move);

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_byte    = rsp_byte_ff;
   assign rsp_if.last_of_run = rsp_last_ff;
   assign rsp_if.truncated   = rsp_trunc_ff;

   // ------------------------------------------------------------------------
   // Decode of one input byte. All emission decisions are made here, against
   // the state before the byte, so that the sequencer only replays.
   // ------------------------------------------------------------------------
   always_comb begin
      logic [BYTE_W-1:0] c;
      logic              eof;
      logic              ws;
      logic              nl;
      logic              cont;
      logic              word_add;
      logic              ind_store;
      logic              blank;
      logic              fin;
      logic              brk;
      logic              ps_f;
      logic [WL_W-1:0]   wlen1;
      logic [WL_W-1:0]   wchars1;
      logic              wovf1;
      logic [LW_W-1:0]   width_eff;
      logic [COL_W:0]    need_cols;
      logic [COL_W:0]    col_sum;
      logic [COL_W-1:0]  col_new;
      logic [COL_W-1:0]  col_after;

      c    = req_if.in_byte;
      eof  = req_if.end_of_file;
      ws   = is_white(c);
      nl   = (c == CH_NL);
      cont = (c[7:6] == 2'b10);

      word_add  = !ws;
      ind_store = ils_ff && ws && !nl && ps_ff;

      // Word after this byte is appended; bytes past the buffer only flag it.
      wlen1   = wlen_ff;
      wchars1 = wchars_ff;
      wovf1   = wovf_ff;
      if (word_add) begin
         if (wlen_ff < WL_W'(WORD_BYTES)) begin
            wlen1 = wlen_ff + 1'b1;
            if (!cont) begin
               wchars1 = wchars_ff + 1'b1;
            end
         end else begin
            wovf1 = 1'b1;
         end
      end

      // A newline on a whitespace-only line, or end of file in the middle of
      // leading whitespace, closes the paragraph. Otherwise a word boundary or
      // end of file flushes the buffered word, if any.
      blank = (ils_ff && nl) || (eof && ils_ff && ws && !nl);
      fin   = !blank && ((!ils_ff && ws) || eof) && (wlen1 != '0);

      width_eff = (lw_ff == '0) ? DEFAULT_WIDTH : lw_ff;
      need_cols = {1'b0, col_ff} + (COL_W+1)'(1) + (COL_W+1)'(wchars1);
      brk       = fin && !ps_ff && (need_cols >= (COL_W+1)'(width_eff));
      ps_f      = ps_ff || brk;

      col_sum = (brk ? '0 : {1'b0, col_ff})
              + (ps_f ? (COL_W+1)'(ilen_ff) : (COL_W+1)'(1))
              + (COL_W+1)'(wchars1);
      col_new = (col_sum > {1'b0, COL_MAX}) ? COL_MAX : col_sum[COL_W-1:0];

      priority if (blank) begin
         col_after = '0;
      end else if (fin) begin
         col_after = col_new;
      end else begin
         col_after = col_ff;
      end

      plan.nl_a   = blank && (col_ff != '0);
      plan.nl_b   = blank;
      plan.brk    = brk;
      plan.ind    = fin && ps_f && (ilen_ff != '0);
      plan.spc    = fin && !ps_f;
      plan.wrd    = fin;
      plan.eof_nl = eof && (col_after != '0);

      wrd_we = accept && word_add && (wlen_ff < WL_W'(WORD_BYTES));
      ind_we = accept && ind_store && (ilen_ff < IL_W'(INDENT_BYTES));

      // Next state. End of file returns everything but line_width to reset.
      ils_in    = ils_ff ? ws : nl;
      ps_in     = blank ? 1'b1 : (fin ? 1'b0 : ps_ff);
      col_in    = col_after;
      ilen_in   = ilen_ff;
      icut_in   = icut_ff;
      if (blank) begin
         ilen_in = '0;
         icut_in = 1'b0;
      end else if (ind_store) begin
         if (ilen_ff < IL_W'(INDENT_BYTES)) begin
            ilen_in = ilen_ff + 1'b1;
         end else begin
            icut_in = 1'b1;
         end
      end
      wlen_in   = fin ? '0 : wlen1;
      wchars_in = fin ? '0 : wchars1;
      wovf_in   = fin ? 1'b0 : wovf1;

      if (eof) begin
         ils_in    = 1'b1;
         ps_in     = 1'b1;
         col_in    = '0;
         ilen_in   = '0;
         icut_in   = 1'b0;
         wlen_in   = '0;
         wchars_in = '0;
         wovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff     <= DEFAULT_WIDTH;
         col_ff    <= '0;
         ps_ff     <= 1'b1;
         ils_ff    <= 1'b1;
         ilen_ff   <= '0;
         icut_ff   <= 1'b0;
         wlen_ff   <= '0;
         wchars_ff <= '0;
         wovf_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            lw_ff <= csr_wdata;
         end
         if (accept) begin
            col_ff    <= col_in;
            ps_ff     <= ps_in;
            ils_ff    <= ils_in;
            ilen_ff   <= ilen_in;
            icut_ff   <= icut_in;
            wlen_ff   <= wlen_in;
            wchars_ff <= wchars_in;
            wovf_ff   <= wovf_in;
         end
      end
   end

   // The frozen lengths describe the buffers as they stand after the decode
   // cycle, which is what the sequencer replays. The byte that ends a word at
   // end of file is already written when the first read is issued.
   always_ff @(posedge clock) begin
      if (accept) begin
         p_ilen_ff <= ilen_ff;
         p_icut_ff <= icut_ff;
         p_wlen_ff <= (req_if.end_of_file && wrd_we) ? wlen_ff + 1'b1 : wlen_ff;
         p_wovf_ff <= wovf_ff || (req_if.end_of_file && !is_white(req_if.in_byte)
                                  && !wrd_we);
      end
   end

   // ------------------------------------------------------------------------
   // Buffers: one write port (decode) and one registered read port
   // (sequencer) each.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ind_we) begin
         ind_mem[ilen_ff[IA_W-1:0]] <= req_if.in_byte;
      end
      if (issue && (phase == PH_IND)) begin
         ind_rd_ff <= ind_mem[idx_ff[IA_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wrd_we) begin
         wrd_mem[wlen_ff[WA_W-1:0]] <= req_if.in_byte;
      end
      if (issue && (phase == PH_WRD)) begin
         wrd_rd_ff <= wrd_mem[idx_ff[WA_W-1:0]];
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer: the first pending job is the current phase. Indent and word
   // jobs step through their bytes; every other job is one byte. The result
   // count stops the run at the result cap.
   // ------------------------------------------------------------------------
   always_comb begin
      logic [CNT_W-1:0] idx_inc;
      logic             done;

      idx_inc = idx_ff + 1'b1;

      priority if (rem_ff.nl_a) begin
         phase = PH_NL_A;
      end else if (rem_ff.nl_b) begin
         phase = PH_NL_B;
      end else if (rem_ff.brk) begin
         phase = PH_BRK;
      end else if (rem_ff.ind) begin
         phase = PH_IND;
      end else if (rem_ff.spc) begin
         phase = PH_SPC;
      end else if (rem_ff.wrd) begin
         phase = PH_WRD;
      end else if (rem_ff.eof_nl) begin
         phase = PH_EOF_NL;
      end else begin
         phase = PH_IDLE;
      end

      rem_in     = rem_ff;
      done       = 1'b1;
      step_trunc = 1'b0;
      unique case (phase)
         PH_NL_A:   rem_in.nl_a   = 1'b0;
         PH_NL_B:   rem_in.nl_b   = 1'b0;
         PH_BRK:    rem_in.brk    = 1'b0;
         PH_SPC:    rem_in.spc    = 1'b0;
         PH_EOF_NL: rem_in.eof_nl = 1'b0;
         PH_IND: begin
            step_trunc = p_icut_ff;
            done       = (idx_inc == CNT_W'(p_ilen_ff));
            rem_in.ind = !done;
         end
         PH_WRD: begin
            step_trunc = p_wovf_ff;
            done       = (idx_inc == CNT_W'(p_wlen_ff));
            rem_in.wrd = !done;
         end
         default: done = 1'b1;
      endcase

      idx_in    = done ? '0 : idx_inc;
      cnt_in    = cnt_ff + 1'b1;
      step_last = (rem_in == '0) || (cnt_ff == RC_W'(RESULT_CAP - 1));
      if (step_last) begin
         rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (accept) begin
         rem_ff <= plan;
         cnt_ff <= '0;
      end else if (issue) begin
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff <= '0;
      end else if (issue) begin
         idx_ff <= idx_in;
      end
   end

   // ------------------------------------------------------------------------
   // Read stage and output register.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (issue) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_move) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_kind_ff  <= phase;
         s1_last_ff  <= step_last;
         s1_trunc_ff <= step_trunc;
      end
      if (s1_move) begin
         unique case (s1_kind_ff)
            PH_IND:  rsp_byte_ff <= ind_rd_ff;
            PH_WRD:  rsp_byte_ff <= wrd_rd_ff;
            PH_SPC:  rsp_byte_ff <= CH_SPACE;
            default: rsp_byte_ff <= CH_NL;
         endcase
         rsp_last_ff  <= s1_last_ff;
         rsp_trunc_ff <= s1_trunc_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // The buffers are never written while their contents are being replayed.
   assert property (@(posedge clock) disable iff (reset)
      (ind_we || wrd_we) |-> (rem_ff == '0))
      else $error("buffer written while emission is pending");

   // End of file leaves the block in its reset state.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.end_of_file) |=>
         (col_ff == '0) && ps_ff && ils_ff && (wlen_ff == '0) && (ilen_ff == '0))
      else $error("state not cleared after end of file");

   // A byte in the read stage is not lost while the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && rsp_valid_ff && !rsp_if.ready) |=> s1_vld_ff)
      else $error("read stage dropped a byte under back pressure");

   // Never more results per input byte than the cap.
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RC_W'(RESULT_CAP))
      else $error("result count exceeded the cap");

endmodule

`default_nettype wire
